>>> src/snm_pkg.sv
package snm_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned PHASE_BITS_DEF       = 32;
    localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned AMP_W       = 15;
    localparam int unsigned COEFF_W     = 16;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned MUL_W       = 17;
    localparam int unsigned PROD_W      = 2 * MUL_W;
    localparam int unsigned ACC_W       = 35;
    localparam int unsigned MAC_CNT_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_AMP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_B0   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_B1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_B2   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_A1   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_A2   = 3'd6;

    // Register reset values.
    localparam logic [31:0]                RST_PHASE_STEP = 32'd71582788;
    localparam logic [AMP_W-1:0]           RST_TONE_AMP   = 15'd0;
    localparam logic signed [COEFF_W-1:0]  RST_COEFF_B0   = 16'sd1105;
    localparam logic signed [COEFF_W-1:0]  RST_COEFF_B1   = 16'sd2210;
    localparam logic signed [COEFF_W-1:0]  RST_COEFF_B2   = 16'sd1105;
    localparam logic signed [COEFF_W-1:0]  RST_COEFF_A1   = -16'sd18726;
    localparam logic signed [COEFF_W-1:0]  RST_COEFF_A2   = 16'sd6763;

    // Last multiply-accumulate step index (five products, then a final add).
    localparam logic [MAC_CNT_W-1:0] MAC_LAST = 3'd5;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_TONE,
        S_MAC,
        S_FILT,
        S_MIX
    } state_t;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // Magnitude of the quarter-wave sine at fold index j, for a table of
    // 2**depth_log2 entries. Only evaluated while the table is elaborated.
    function automatic logic [AMP_W-1:0] sine_mag(input int unsigned j,
                                                  input int unsigned depth_log2);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] s;
        longint      sum;
        x   = ((64'(j) * 64'd4) * HALF_PI_Q30) >> depth_log2;
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        mag = ((mag * x2) >> 30) / 64'd6;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + longint'(mag);
        if (sum < 0)
        begin
            sum = 0;
        end
        s = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[AMP_W-1:0];
    endfunction

endpackage

>>> src/snm_sine_rom.sv
module snm_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = snm_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH) - 1
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ADDR_W-1:0]            addr,
    output logic [snm_pkg::AMP_W-1:0]    data
);
    import snm_pkg::*;

    // Quarter wave plus its end point: indexes 0 to depth/4 inclusive.
    localparam int unsigned ENTRIES = SINE_TABLE_DEPTH / 4 + 1;
    localparam int unsigned DEPTH_LOG2 = $clog2(SINE_TABLE_DEPTH);

    typedef logic [AMP_W-1:0] rom_t [ENTRIES];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < ENTRIES; i++)
        begin
            t[i] = sine_mag(i, DEPTH_LOG2);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [AMP_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

>>> src/snm_mul.sv
module snm_mul (
    input  logic                                clk,
    input  snm_pkg::mul_req_t                   req,
    output logic signed [snm_pkg::PROD_W-1:0]   prod
);
    import snm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // Registered signed multiply; the product holds until the next request.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

>>> src/sidetone_nco_biquad_mixer_top.sv
// A word accepted on the input passes through the scale, tone, multiply-accumulate, filter
// and mix states in turn, and no new word is taken until its result is loaded; the single
// shared multiplier carries the tone scaling and the five filter products in turn.
// A result waiting in the output register stalls only the final mix step.
// Reset (rst_n low, asynchronous) clears the phase, the filter history and
// the output valid flag, and loads the register defaults.
module sidetone_nco_biquad_mixer_top #(
    parameter int unsigned PHASE_BITS       = snm_pkg::PHASE_BITS_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = snm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] audio_in
    // Output stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] mixed_out
    output logic [0:0]                         m_tuser,   // [0] clipped
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [snm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [snm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import snm_pkg::*;

    // The sine table depth is a power of two; the top address bits of the
    // phase select an entry, the upper two of those give the quadrant.
    localparam int unsigned ADDR_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned QBITS   = ADDR_W - 2;
    localparam int unsigned ROM_AW  = QBITS + 1;
    localparam int unsigned QDEPTH  = SINE_TABLE_DEPTH / 4;
    localparam int unsigned SHIFT_W = ACC_W - 14;

    localparam logic signed [SHIFT_W-1:0] FILT_MAX = SHIFT_W'(32767);
    localparam logic signed [SHIFT_W-1:0] FILT_MIN = -SHIFT_W'(32768);
    localparam logic signed [SAMPLE_W:0]  MIX_MAX  = (SAMPLE_W+1)'(32767);
    localparam logic signed [SAMPLE_W:0]  MIX_MIN  = -(SAMPLE_W+1)'(32768);

    // Configuration registers.
    logic [PHASE_BITS-1:0]        phase_step_reg;
    logic [AMP_W-1:0]             tone_amp_reg;
    logic signed [COEFF_W-1:0]    coeff_b0_reg;
    logic signed [COEFF_W-1:0]    coeff_b1_reg;
    logic signed [COEFF_W-1:0]    coeff_b2_reg;
    logic signed [COEFF_W-1:0]    coeff_a1_reg;
    logic signed [COEFF_W-1:0]    coeff_a2_reg;

    // Oscillator and filter state.
    logic [PHASE_BITS-1:0]        phase_acc_reg;
    logic signed [SAMPLE_W-1:0]   tone_d1_reg;
    logic signed [SAMPLE_W-1:0]   tone_d2_reg;
    logic signed [SAMPLE_W-1:0]   filt_d1_reg;
    logic signed [SAMPLE_W-1:0]   filt_d2_reg;

    // Sequencer and working registers.
    state_t                       state_reg;
    state_t                       state_next;
    logic [MAC_CNT_W-1:0]         cnt_reg;
    logic [MAC_CNT_W-1:0]         cnt_next;
    logic signed [SAMPLE_W-1:0]   audio_reg;
    logic                         neg_reg;
    logic signed [SAMPLE_W-1:0]   tone_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_next;
    logic signed [SAMPLE_W-1:0]   y_reg;
    logic                         sat_reg;

    // Output register.
    logic                         out_valid_reg;
    logic [SAMPLE_W-1:0]          out_data_reg;
    logic                         out_clip_reg;

    logic                         in_fire;
    logic                         out_load;
    mul_req_t                     mul_req;
    logic signed [PROD_W-1:0]     prod;
    logic [AMP_W-1:0]             sine_mag;

    logic [ADDR_W-1:0]            table_idx;
    logic [1:0]                   quad;
    logic [QBITS-1:0]             quad_off;
    logic [ROM_AW-1:0]            rom_addr;

    logic signed [SHIFT_W-1:0]    filt_q;
    logic signed [SAMPLE_W-1:0]   filt_y;
    logic                         filt_sat;
    logic signed [SAMPLE_W:0]     mix_sum;
    logic signed [SAMPLE_W-1:0]   mix_y;
    logic                         mix_sat;
    logic [AMP_W-1:0]             tone_mag;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Table address: the phase is folded onto a quarter wave. In the odd
    // quadrants the offset runs backwards, so an offset of zero lands on the
    // peak entry at the end of the quarter.
    assign table_idx = phase_acc_reg[PHASE_BITS-1 -: ADDR_W];
    assign quad      = table_idx[ADDR_W-1 -: 2];
    assign quad_off  = table_idx[QBITS-1:0];
    assign rom_addr  = quad[0] ? (ROM_AW'(QDEPTH) - {1'b0, quad_off}) : {1'b0, quad_off};

    snm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .en   (in_fire),
        .addr (rom_addr),
        .data (sine_mag)
    );

    snm_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Tone magnitude truncates towards zero; the sine's sign is applied after.
    assign tone_mag = prod[2*AMP_W-1:AMP_W];

    // Floor division by 2**14 is an arithmetic shift; then clamp to 16 bits.
    assign filt_q = acc_reg[ACC_W-1:14];

    always_comb
    begin
        filt_sat = 1'b0;
        filt_y   = filt_q[SAMPLE_W-1:0];
        if (filt_q > FILT_MAX)
        begin
            filt_sat = 1'b1;
            filt_y   = FILT_MAX[SAMPLE_W-1:0];
        end
        else if (filt_q < FILT_MIN)
        begin
            filt_sat = 1'b1;
            filt_y   = FILT_MIN[SAMPLE_W-1:0];
        end
    end

    assign mix_sum = {y_reg[SAMPLE_W-1], y_reg} + {audio_reg[SAMPLE_W-1], audio_reg};

    always_comb
    begin
        mix_sat = 1'b0;
        mix_y   = mix_sum[SAMPLE_W-1:0];
        if (mix_sum > MIX_MAX)
        begin
            mix_sat = 1'b1;
            mix_y   = MIX_MAX[SAMPLE_W-1:0];
        end
        else if (mix_sum < MIX_MIN)
        begin
            mix_sat = 1'b1;
            mix_y   = MIX_MIN[SAMPLE_W-1:0];
        end
    end

    // Sequencer. The multiply-accumulate runs six steps: steps 0 to 4 issue
    // one product each, steps 1 to 5 add the product of the step before.
    // The two feedback products are subtracted.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        out_load   = 1'b0;
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {2'b00, tone_amp_reg};
                mul_req.b  = {2'b00, sine_mag};
                state_next = S_TONE;
            end
            S_TONE:
            begin
                cnt_next   = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                mul_req.en = (cnt_reg != MAC_LAST);
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_req.a = {coeff_b0_reg[COEFF_W-1], coeff_b0_reg};
                        mul_req.b = {tone_reg[SAMPLE_W-1], tone_reg};
                    end
                    3'd1:
                    begin
                        mul_req.a = {coeff_b1_reg[COEFF_W-1], coeff_b1_reg};
                        mul_req.b = {tone_d1_reg[SAMPLE_W-1], tone_d1_reg};
                    end
                    3'd2:
                    begin
                        mul_req.a = {coeff_b2_reg[COEFF_W-1], coeff_b2_reg};
                        mul_req.b = {tone_d2_reg[SAMPLE_W-1], tone_d2_reg};
                    end
                    3'd3:
                    begin
                        mul_req.a = {coeff_a1_reg[COEFF_W-1], coeff_a1_reg};
                        mul_req.b = {filt_d1_reg[SAMPLE_W-1], filt_d1_reg};
                    end
                    3'd4:
                    begin
                        mul_req.a = {coeff_a2_reg[COEFF_W-1], coeff_a2_reg};
                        mul_req.b = {filt_d2_reg[SAMPLE_W-1], filt_d2_reg};
                    end
                    default:
                    begin
                        mul_req.a = '0;
                        mul_req.b = '0;
                    end
                endcase

                case (cnt_reg)
                    3'd0:
                    begin
                        acc_next = '0;
                    end
                    3'd4, 3'd5:
                    begin
                        acc_next = acc_reg - ACC_W'(prod);
                    end
                    default:
                    begin
                        acc_next = acc_reg + ACC_W'(prod);
                    end
                endcase

                if (cnt_reg == MAC_LAST)
                begin
                    state_next = S_FILT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_FILT:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, oscillator and filter history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_acc_reg <= '0;
            tone_d1_reg   <= '0;
            tone_d2_reg   <= '0;
            filt_d1_reg   <= '0;
            filt_d2_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_FILT)
            begin
                tone_d2_reg <= tone_d1_reg;
                tone_d1_reg <= tone_reg;
                filt_d2_reg <= filt_d1_reg;
                filt_d1_reg <= filt_y;
            end
            if (out_load)
            begin
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire)
        begin
            audio_reg <= s_tdata;
            neg_reg   <= quad[1];
        end
        if (state_reg == S_TONE)
        begin
            tone_reg <= neg_reg ? -$signed({1'b0, tone_mag}) : $signed({1'b0, tone_mag});
        end
        if (state_reg == S_FILT)
        begin
            y_reg   <= filt_y;
            sat_reg <= filt_sat;
        end
        if (out_load)
        begin
            out_data_reg <= mix_y;
            out_clip_reg <= sat_reg || mix_sat;
        end
    end

    // Configuration registers; writes to unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_BITS'(RST_PHASE_STEP);
            tone_amp_reg   <= RST_TONE_AMP;
            coeff_b0_reg   <= RST_COEFF_B0;
            coeff_b1_reg   <= RST_COEFF_B1;
            coeff_b2_reg   <= RST_COEFF_B2;
            coeff_a1_reg   <= RST_COEFF_A1;
            coeff_a2_reg   <= RST_COEFF_A2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= PHASE_BITS'(cfg_data);
                REG_TONE_AMP:   tone_amp_reg   <= cfg_data[AMP_W-1:0];
                REG_COEFF_B0:   coeff_b0_reg   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_B1:   coeff_b1_reg   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_B2:   coeff_b2_reg   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_A1:   coeff_a1_reg   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_A2:   coeff_a2_reg   <= cfg_data[COEFF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_clip_reg;

    // An accepted word always starts with the tone scaling step.
    a_accept_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_SCALE)
        else $error("accepted word did not start the scaling step");

    // The phase only advances when a result is loaded.
    a_phase_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_acc_reg) |-> $past(out_load))
        else $error("phase moved without a result being loaded");

    // The multiply-accumulate counter never runs past its last step.
    a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> cnt_reg <= MAC_LAST)
        else $error("multiply-accumulate counter out of range");

    // Leaving the multiply-accumulate loop happens only after its last step.
    a_mac_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC && cnt_reg != MAC_LAST |=> state_reg == S_MAC)
        else $error("multiply-accumulate loop left early");

endmodule

>>> dv/tb_sidetone_nco_biquad_mixer_top.sv
// Self-checking bench for the sidetone mixer. A driver feeds audio words from a queue that the
// stimulus process fills, a monitor checks every output word against a bit-exact model of the
// oscillator, the biquad and the saturating mix, kept here with its own copy of the registers.
module tb_sidetone_nco_biquad_mixer_top;

    import snm_pkg::*;

    localparam int unsigned PHASE_W    = PHASE_BITS_DEF;
    localparam int unsigned SINE_DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam int unsigned IDX_W      = $clog2(SINE_DEPTH);
    // Quarter turn in Q30, used to build the sine table.
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    // Generous bound for a run of about 800 words.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned END_PAUSE   = 40;
    localparam int unsigned MAX_PRINTED = 100;

    typedef struct packed {
        logic signed [15:0] mixed;
        logic               clip;
    } mix_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Audio words waiting for the driver, and the results the model expects, oldest first.
    logic signed [15:0] pending_audio_q[$];
    mix_result_t        expected_mix_q[$];

    int unsigned words_sent = 0;
    int unsigned words_accepted = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    // Chance in a hundred that a side idles in a given cycle; both sides share it.
    int unsigned idle_pct = 30;
    mix_result_t mon_want;

    // Model copy of the registers.
    logic [31:0]        step_reg;
    logic [14:0]        amp_reg;
    logic signed [15:0] cf_b0, cf_b1, cf_b2, cf_a1, cf_a2;

    // Model copy of the oscillator phase and the filter history.
    logic [PHASE_W-1:0] nco_phase = '0;
    logic signed [15:0] tone_hist1 = '0;
    logic signed [15:0] tone_hist2 = '0;
    logic signed [15:0] filt_hist1 = '0;
    logic signed [15:0] filt_hist2 = '0;

    int sine_lut [0:SINE_DEPTH-1];

    sidetone_nco_biquad_mixer_top #(
        .PHASE_BITS       (PHASE_W),
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] audio_in
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [15:0] mixed_out
        .m_tuser   (m_tuser),   // [0] clipped
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // One Q1.15 sine table entry: fold onto the first quarter, Taylor series to the x^13 term in
    // Q30, then round to Q15, clamp and put the sign back for the second half-turn.
    function automatic int sine_q15(input int unsigned k);
        longint unsigned t, quad, r, x, x2, term, s;
        longint          acc;
        int              n;
        t = longint'(k % SINE_DEPTH) * 4;
        quad = t / SINE_DEPTH;
        r = t % SINE_DEPTH;
        if ((quad & 1) != 0)
            r = SINE_DEPTH - r;
        x = (r * QUARTER_TURN_Q30) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        s = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
        if (s > 32767)
            s = 32767;
        return (quad >= 2) ? -int'(s) : int'(s);
    endfunction

    // Saturate to the 16-bit sample range and note whether it bit.
    function automatic longint clamp16(input longint v, inout logic hit);
        if (v > 32767)
        begin
            hit = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            hit = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // Works out the mixed word for one accepted audio word and advances the model state.
    function automatic mix_result_t predict_mix(input logic signed [15:0] audio);
        logic [IDX_W-1:0]   idx;
        int                 sine;
        int unsigned        smag, tmag;
        logic signed [15:0] tone;
        longint             acc, filt, mix;
        logic               hit;
        mix_result_t        res;
        hit = 1'b0;
        // The phase before this word's advance picks the table entry.
        idx = IDX_W'((longint'(nco_phase) * SINE_DEPTH) >> PHASE_W);
        sine = sine_lut[idx];
        smag = (sine < 0) ? -sine : sine;
        // Scaling truncates the magnitude towards zero; the sign goes back on afterwards.
        tmag = (int'(amp_reg) * smag) >> 15;
        tone = 16'((sine < 0) ? -int'(tmag) : int'(tmag));
        acc = longint'(cf_b0) * longint'(tone)
            + longint'(cf_b1) * longint'(tone_hist1)
            + longint'(cf_b2) * longint'(tone_hist2)
            - longint'(cf_a1) * longint'(filt_hist1)
            - longint'(cf_a2) * longint'(filt_hist2);
        // Arithmetic shift floors, as the Q2.14 rescale requires.
        filt = clamp16(acc >>> 14, hit);
        tone_hist2 = tone_hist1;
        tone_hist1 = tone;
        filt_hist2 = filt_hist1;
        filt_hist1 = 16'(filt);
        mix = clamp16(filt + longint'(audio), hit);
        nco_phase = nco_phase + PHASE_W'(step_reg);
        res.mixed = 16'(mix);
        res.clip = hit;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Register write, taken at the next rising edge; the model copy follows it at once, which is
    // safe because writes are only issued while nothing is in flight.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_PHASE_STEP: step_reg = val;
            REG_TONE_AMP:   amp_reg = val[14:0];
            REG_COEFF_B0:   cf_b0 = val[15:0];
            REG_COEFF_B1:   cf_b1 = val[15:0];
            REG_COEFF_B2:   cf_b2 = val[15:0];
            REG_COEFF_A1:   cf_a1 = val[15:0];
            REG_COEFF_A2:   cf_a2 = val[15:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued word has gone in and every result has come out.
    task automatic wait_drained();
        while (pending_audio_q.size() != 0 || words_accepted != words_sent
               || expected_mix_q.size() != 0)
            @(posedge clk);
    endtask

    // A coefficient word carries junk in the upper half, which the block must ignore.
    function automatic logic [31:0] coeff_word(input int v);
        return {16'($urandom()), 16'(v)};
    endfunction

    function automatic int wild_coeff();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic logic [15:0] pick_audio();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'(int'($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom());
        endcase
    endfunction

    // Loads a fresh setting. Shape 0 keeps the default low-pass, shape 1 uses small coefficients
    // that keep the feedback well inside stability, shape 2 allows anything, extremes included.
    task automatic load_setting(input int shape);
        logic [31:0] step_val;
        int          amp_val;
        case ($urandom_range(0, 7))
            0:       step_val = 32'h0000_0000;
            1:       step_val = 32'hFFFF_FFFF;
            2, 3, 4: step_val = $urandom_range(0, 32'h0800_0000);
            default: step_val = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       amp_val = 0;
            1:       amp_val = 32767;
            default: amp_val = int'($urandom_range(0, 32767));
        endcase
        write_reg(REG_PHASE_STEP, step_val);
        write_reg(REG_TONE_AMP, ($urandom() & 32'hFFFF_8000) | 32'(amp_val));
        case (shape)
            0:
            begin
                write_reg(REG_COEFF_B0, coeff_word(int'(RST_COEFF_B0)));
                write_reg(REG_COEFF_B1, coeff_word(int'(RST_COEFF_B1)));
                write_reg(REG_COEFF_B2, coeff_word(int'(RST_COEFF_B2)));
                write_reg(REG_COEFF_A1, coeff_word(int'(RST_COEFF_A1)));
                write_reg(REG_COEFF_A2, coeff_word(int'(RST_COEFF_A2)));
            end
            1:
            begin
                write_reg(REG_COEFF_B0, coeff_word(int'($urandom_range(0, 16383)) - 8192));
                write_reg(REG_COEFF_B1, coeff_word(int'($urandom_range(0, 16383)) - 8192));
                write_reg(REG_COEFF_B2, coeff_word(int'($urandom_range(0, 16383)) - 8192));
                write_reg(REG_COEFF_A1, coeff_word(int'($urandom_range(0, 8191)) - 4096));
                write_reg(REG_COEFF_A2, coeff_word(int'($urandom_range(0, 8191)) - 4096));
            end
            default:
            begin
                write_reg(REG_COEFF_B0, coeff_word(wild_coeff()));
                write_reg(REG_COEFF_B1, coeff_word(wild_coeff()));
                write_reg(REG_COEFF_B2, coeff_word(wild_coeff()));
                write_reg(REG_COEFF_A1, coeff_word(wild_coeff()));
                write_reg(REG_COEFF_A2, coeff_word(wild_coeff()));
            end
        endcase
    endtask

    // Driver: a word stays on the bus until it is taken; only then may the next one go out, or
    // the source go idle.
    always @(negedge clk)
    begin
        if (rst_n && words_accepted == words_sent)
        begin
            if (pending_audio_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_audio_q.pop_front();
                words_sent++;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The sink stalls at random, at the same rate as the source idles.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Monitor: outputs are checked before the input of the same edge is predicted, since a result
    // can never belong to a word accepted at that very edge.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_mix_q.size() == 0)
                begin
                    report_mismatch($sformatf("output word %h with nothing expected", m_tdata));
                end
                else
                begin
                    mon_want = expected_mix_q.pop_front();
                    if (m_tdata !== mon_want.mixed)
                        report_mismatch($sformatf("mixed_out %h, expected %h",
                                                  m_tdata, mon_want.mixed));
                    if (m_tuser[0] !== mon_want.clip)
                        report_mismatch($sformatf("clipped %b, expected %b",
                                                  m_tuser[0], mon_want.clip));
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_mix_q.push_back(predict_mix(s_tdata));
                words_accepted++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int unsigned i;
        int          p;
        int          shape;
        int unsigned roll;

        foreach (sine_lut[j])
            sine_lut[j] = sine_q15(j);

        // The model starts from the register defaults, as the block does after reset.
        step_reg = RST_PHASE_STEP;
        amp_reg = RST_TONE_AMP;
        cf_b0 = RST_COEFF_B0;
        cf_b1 = RST_COEFF_B1;
        cf_b2 = RST_COEFF_B2;
        cf_a1 = RST_COEFF_A1;
        cf_a2 = RST_COEFF_A2;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Defaults: zero amplitude, so the audio extremes must pass straight through.
        pending_audio_q.push_back(16'sh7FFF);
        pending_audio_q.push_back(16'sh8000);
        pending_audio_q.push_back(16'sh0000);
        pending_audio_q.push_back(16'shFFFF);
        pending_audio_q.push_back(16'sh0001);
        pending_audio_q.push_back(16'sh5555);
        wait_drained();

        // Quarter-turn steps walk the zero crossings and both peaks at full scale; the extreme
        // coefficients drive the filter into saturation in both directions, and audio at the
        // rails saturates the sum. A write to the unused index must leave the registers alone.
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_TONE_AMP, 32'h0000_7FFF);
        write_reg(REG_COEFF_B0, 32'h0000_7FFF);
        write_reg(REG_COEFF_B1, 32'hFFFF_8000);
        write_reg(REG_COEFF_B2, 32'h0000_7FFF);
        write_reg(REG_COEFF_A1, 32'h0000_0000);
        write_reg(REG_COEFF_A2, 32'h0000_0000);
        write_reg(REG_UNUSED, $urandom());
        pending_audio_q.push_back(16'sh7FFF);
        pending_audio_q.push_back(16'sh7FFF);
        pending_audio_q.push_back(16'sh8000);
        pending_audio_q.push_back(16'sh8000);
        pending_audio_q.push_back(16'sh0000);
        pending_audio_q.push_back(16'sh0000);
        pending_audio_q.push_back(16'sh0000);
        pending_audio_q.push_back(16'sh0000);
        wait_drained();

        // A step of all ones wraps the phase at once; feedback at the coefficient extremes
        // runs away and must clip.
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_TONE_AMP, 32'h0000_4000);
        write_reg(REG_COEFF_B0, 32'h0000_4000);
        write_reg(REG_COEFF_B1, 32'h0000_0000);
        write_reg(REG_COEFF_B2, 32'h0000_0000);
        write_reg(REG_COEFF_A1, 32'h0000_8000);
        write_reg(REG_COEFF_A2, 32'h0000_7FFF);
        for (i = 0; i < 8; i++)
            pending_audio_q.push_back(pick_audio());
        wait_drained();

        // Random part. Most settings keep the filter stable so the history stays meaningful;
        // one phase runs with no idling on either side.
        for (p = 0; p < 8; p++)
        begin
            roll = $urandom_range(0, 9);
            if (p == 0)
                shape = 0;
            else if (p == 7)
                shape = 2;
            else if (roll < 4)
                shape = 0;
            else if (roll < 8)
                shape = 1;
            else
                shape = 2;
            load_setting(shape);
            if (p == 3)
                write_reg(REG_UNUSED, $urandom());
            idle_pct = (p == 3) ? 0 : 30;
            for (i = 0; i < 95; i++)
                pending_audio_q.push_back(pick_audio());
            wait_drained();
        end

        idle_pct = 30;
        repeat (END_PAUSE) @(posedge clk);
        if (expected_mix_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_mix_q.size()));

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
